FILE: hw/rtl/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants of the rectangle fit residual unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rfr_pkg;
  localparam int unsigned MaxPointsDefault = 1024;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DistW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_HALF_W    = 3'd2,
    CFG_HALF_H    = 3'd3,
    CFG_HUBER     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic side_step;
    logic acc;
    logic div_start;
    logic div_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic side_done;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rfr_ctrl.sv
// ----------------------------------------------------------------------------
// rfr_ctrl
// Sequencer: load, four side steps, accumulate, optional mean divide, output.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire rfr_pkg::stat_t stat_i,
  output rfr_pkg::ctrl_t      ctrl_o
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SIDE = 6'b000010,
    S_ACC  = 6'b000100,
    S_DIV0 = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        ctrl_o.load = 1'b1;
        state_d = S_SIDE;
      end
      S_SIDE: begin
        ctrl_o.side_step = 1'b1;
        if (stat_i.side_done) state_d = S_ACC;
      end
      S_ACC: begin
        ctrl_o.acc = 1'b1;
        state_d = stat_i.last ? S_DIV0 : S_OUT;
      end
      S_DIV0: begin
        ctrl_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) begin
        ctrl_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rfr_dp.sv
// ----------------------------------------------------------------------------
// rfr_dp
// Datapath: side distances with Huber step, running sum, restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_dp #(
  parameter int unsigned MaxPoints = rfr_pkg::MaxPointsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic signed [19:0]   px_i,
  input  wire logic signed [19:0]   py_i,
  input  wire logic signed [7:0]    pw_i,
  input  wire logic                 plast_i,
  input  wire rfr_pkg::ctrl_t       ctrl_i,
  output rfr_pkg::stat_t            stat_o,
  output logic [31:0]               residual_o,
  output logic [31:0]               mean_o,
  output logic                      rlast_o
);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  logic signed [19:0] cx_q, cy_q;
  logic [18:0] hw_q, hh_q;
  logic [31:0] thr_q;
  logic signed [19:0] x_q, y_q;
  logic signed [7:0] w_q;
  logic last_q;
  logic [1:0] side_q;
  logic [rfr_pkg::DistW-1:0] best_q;
  logic [31:0] res_q;
  logic [63:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic [63:0] rem_q, quo_q;
  logic [6:0] dcnt_q;
  logic [31:0] mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; hw_q <= 19'd1000; hh_q <= 19'd1000; thr_q <= '0;
    end else if (cfg_we_i) begin
      case (rfr_pkg::cfg_idx_e'(cfg_idx_i))
        rfr_pkg::CFG_CENTER_X: cx_q <= cfg_data_i[19:0];
        rfr_pkg::CFG_CENTER_Y: cy_q <= cfg_data_i[19:0];
        rfr_pkg::CFG_HALF_W:   hw_q <= cfg_data_i[18:0];
        rfr_pkg::CFG_HALF_H:   hh_q <= cfg_data_i[18:0];
        rfr_pkg::CFG_HUBER:    thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one side per cycle: e = center +/- half, |p - e*w| * 256
  logic signed [21:0] e;
  logic signed [20:0] ofs;
  logic signed [19:0] p, c;
  logic signed [29:0] ew;
  logic signed [30:0] diff;
  logic [30:0] mag;
  logic [rfr_pkg::DistW-1:0] d, dh;

  always_comb begin
    p   = side_q[0] ? y_q : x_q;
    c   = side_q[0] ? cy_q : cx_q;
    ofs = side_q[0] ? $signed({2'b0, hh_q}) : $signed({2'b0, hw_q});
    e   = side_q[1] ? (22'(c) - 22'(ofs)) : (22'(c) + 22'(ofs));
    ew  = 30'(e) * 30'(w_q);
    diff = 31'(p) - 31'(ew);
    mag = diff[30] ? 31'(-diff) : 31'(diff);
    d   = {1'b0, mag, 8'd0};
    dh  = (d > rfr_pkg::DistW'(thr_q)) ? d - rfr_pkg::DistW'(thr_q[31:1]) : d;
  end

  assign stat_o.side_done = (side_q == 2'd3);
  assign stat_o.last = last_q;
  assign stat_o.div_done = (dcnt_q == 7'd0);

  logic [31:0] res_sat;
  assign res_sat = (best_q > 40'hFFFFFFFF) ? 32'hFFFFFFFF : best_q[31:0];
  logic [64:0] trial;
  assign trial = {rem_q[62:0], quo_q[63]} - {1'b0, 64'(cnt_q)};
  logic [63:0] sum_new;
  assign sum_new = sum_q + 64'(res_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0; cnt_q <= '0; side_q <= '0; dcnt_q <= '0;
    end else begin
      if (ctrl_i.load) side_q <= '0;
      else if (ctrl_i.side_step) side_q <= side_q + 2'd1;
      if (ctrl_i.acc && (cnt_q < CntW'(MaxPoints))) begin
        sum_q <= sum_new;
        cnt_q <= cnt_q + CntW'(1);
      end
      if (ctrl_i.div_start) dcnt_q <= 7'd64;
      else if (ctrl_i.div_step && dcnt_q != 7'd0) dcnt_q <= dcnt_q - 7'd1;
      if (ctrl_i.finish && last_q) begin
        sum_q <= '0; cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= px_i; y_q <= py_i; w_q <= pw_i; last_q <= plast_i; mean_q <= '0;
    end
    if (ctrl_i.side_step) begin
      if (side_q == 2'd0 || dh < best_q) best_q <= dh;
    end
    if (ctrl_i.acc) res_q <= res_sat;
    if (ctrl_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_q + 64'(cnt_q >> 1);
    end else if (ctrl_i.div_step && dcnt_q != 7'd0) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
    if (ctrl_i.div_step && dcnt_q == 7'd0)
      mean_q <= (cnt_q == '0) ? '0 : ((|quo_q[63:32]) ? 32'hFFFFFFFF : quo_q[31:0]);
  end

  assign residual_o = res_q;
  assign mean_o = mean_q;
  assign rlast_o = last_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rectangle_fit_residual_unit.sv
// ----------------------------------------------------------------------------
// rectangle_fit_residual_unit
// Least robust point-to-rectangle side distance with mean over a point set.
// ----------------------------------------------------------------------------
// One point at a time: the result follows the side loop over the four sides
// and, for a last point, the 64-step restoring divider that forms the mean.
// The next point is taken once the result has been handed on in S_OUT and
// the sequencer is back in S_IDLE. Stall on the output holds the result.
`default_nettype none
module rectangle_fit_residual_unit #(
  parameter int unsigned MaxPoints = rfr_pkg::MaxPointsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [19:0] point_x_i,
  input  wire logic signed [19:0] point_y_i,
  input  wire logic signed [7:0]  point_w_i,
  input  wire logic               last_point_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             point_residual_o,
  output logic [31:0]             mean_residual_o,
  output logic                    result_last_o
);
  rfr_pkg::ctrl_t ctrl;
  rfr_pkg::stat_t stat;

  rfr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .stat_i(stat), .ctrl_o(ctrl)
  );

  rfr_dp #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .px_i(point_x_i), .py_i(point_y_i), .pw_i(point_w_i), .plast_i(last_point_i),
    .ctrl_i(ctrl), .stat_o(stat), .residual_o(point_residual_o),
    .mean_o(mean_residual_o), .rlast_o(result_last_o)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/rfr_checker.sv
// ----------------------------------------------------------------------------
// rfr_checker
// Port-level checks of the rectangle fit residual unit.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] point_residual_o,
  input wire logic [31:0] mean_residual_o,
  input wire logic        result_last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(point_residual_o))
    else $error("stalled result changed");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_last_o |-> mean_residual_o == 32'd0)
    else $error("mean on non-last result");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("accept did not start work");
endmodule

bind rectangle_fit_residual_unit rfr_checker u_rfr_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rectangle_fit_residual_unit: a predictor computes
// the least robust side distance and the set mean per point; random bursts,
// output stalls and several rectangle settings, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  localparam int unsigned MaxPts = 1024;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [7:0]  w;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [31:0] resid;
    logic [31:0] mean;
    logic        last;
  } resid_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [19:0] px, py;
  logic signed [7:0] pw;
  logic plast;
  logic out_valid, out_stall;
  logic [31:0] o_resid, o_mean;
  logic o_last;

  rectangle_fit_residual_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(px), .point_y_i(py), .point_w_i(pw), .last_point_i(plast),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .point_residual_o(o_resid), .mean_residual_o(o_mean), .result_last_o(o_last)
  );

  // rectangle model state
  logic signed [19:0] rect_cx, rect_cy;
  logic [18:0] rect_hw, rect_hh;
  logic [31:0] huber_thr;
  logic [63:0] set_sum;
  int unsigned set_cnt;

  point_t pending_pts[$];
  resid_t expected_resids[$];
  int unsigned mismatches;
  int unsigned n_sent;
  bit hold_off;
  longint unsigned cycles;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] robust_side(logic signed [63:0] p, logic signed [63:0] e,
                                               logic signed [63:0] w);
    logic signed [63:0] diff;
    logic [63:0] d;
    diff = p - e * w;
    d = (diff < 0) ? -diff : diff;
    d = d << 8;
    if (d > {32'd0, huber_thr}) d = d - {33'd0, huber_thr[31:1]};
    return d;
  endfunction

  function automatic resid_t predict_residual(point_t pt);
    logic signed [63:0] x, y, w, cx, cy, hw, hh;
    logic [63:0] best, d, mean;
    resid_t r;
    x = pt.x; y = pt.y; w = pt.w;
    cx = rect_cx; cy = rect_cy;
    hw = {45'd0, rect_hw}; hh = {45'd0, rect_hh};
    best = robust_side(x, cx + hw, w);
    d = robust_side(y, cy - hh, w); if (d < best) best = d;
    d = robust_side(x, cx - hw, w); if (d < best) best = d;
    d = robust_side(y, cy + hh, w); if (d < best) best = d;
    if (best > 64'hFFFF_FFFF) best = 64'hFFFF_FFFF;
    if (set_cnt < MaxPts) begin
      set_sum = set_sum + best;
      set_cnt++;
    end
    mean = 0;
    if (pt.last) begin
      if (set_cnt != 0) mean = (set_sum + (set_cnt >> 1)) / set_cnt;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      set_sum = 0;
      set_cnt = 0;
    end
    r.resid = best[31:0];
    r.mean = mean[31:0];
    r.last = pt.last;
    return r;
  endfunction

  function automatic void add_point(point_t pt);
    pending_pts.insert(pending_pts.size(), pt);
  endfunction

  task automatic write_reg(rfr_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfr_pkg::CFG_CENTER_X: rect_cx = val[19:0];
      rfr_pkg::CFG_CENTER_Y: rect_cy = val[19:0];
      rfr_pkg::CFG_HALF_W:   rect_hw = val[18:0];
      rfr_pkg::CFG_HALF_H:   rect_hh = val[18:0];
      default:               huber_thr = val;
    endcase
  endtask

  task automatic set_rect(logic [31:0] cx, logic [31:0] cy, logic [31:0] hw,
                          logic [31:0] hh, logic [31:0] thr);
    write_reg(rfr_pkg::CFG_CENTER_X, cx);
    write_reg(rfr_pkg::CFG_CENTER_Y, cy);
    write_reg(rfr_pkg::CFG_HALF_W, hw);
    write_reg(rfr_pkg::CFG_HALF_H, hh);
    write_reg(rfr_pkg::CFG_HUBER, thr);
  endtask

  task automatic wait_drained();
    while (pending_pts.size() != 0 || expected_resids.size() != 0 || in_valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic point_t mk_point(int x, int y, int w, bit last);
    point_t p;
    p.x = 20'(x); p.y = 20'(y); p.w = 8'(w); p.last = last;
    return p;
  endfunction

  function automatic int rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20'hFFFFF) - 524288;
      1: return $urandom_range(0, 8000) - 4000;
      2: return ($urandom_range(0, 1) ? 524287 : -524288);
      default: return $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  function automatic int rnd_w();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255) - 128;
      1: return 0;
      default: return 1;
    endcase
  endfunction

  task automatic queue_sets(int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1100) : $urandom_range(1, 40);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        add_point(mk_point(rnd_coord(), rnd_coord(), rnd_w(),
                           (i == len - 1) || ($urandom_range(0, 60) == 0)));
      left -= len;
    end
  endtask

  // driver: bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic bit take = 1'b0;
      automatic point_t p;
      if (in_valid && !in_stall) begin
        expected_resids.insert(expected_resids.size(),
                               predict_residual({px, py, pw, plast}));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (!hold_off && pending_pts.size() != 0) begin
          take = 1'b1;
        end
        if (take) begin
          p = pending_pts.pop_front();
          in_valid <= 1'b1;
          px <= p.x; py <= p.y; pw <= p.w; plast <= p.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor with output stall pattern
  int stall_mode;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_resids.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", o_resid);
        end else begin
          automatic resid_t e = expected_resids.pop_front();
          if (e.resid !== o_resid || e.mean !== o_mean || e.last !== o_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp resid %0d mean %0d last %0b, got %0d %0d %0b",
                       e.resid, e.mean, e.last, o_resid, o_mean, o_last);
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    cycles = 0; mismatches = 0; n_sent = 0; hold_off = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = rfr_pkg::CFG_CENTER_X; cfg_data = '0;
    in_valid = 1'b0; px = '0; py = '0; pw = '0; plast = 1'b0; out_stall = 1'b0;
    rect_cx = '0; rect_cy = '0; rect_hw = 19'd1000; rect_hh = 19'd1000; huber_thr = '0;
    set_sum = '0; set_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset rectangle, extremes, zero and negative w
    add_point(mk_point(0, 0, 1, 0));
    add_point(mk_point(1000, 0, 1, 0));
    add_point(mk_point(524287, 524287, 127, 0));
    add_point(mk_point(-524288, -524288, -128, 0));
    add_point(mk_point(-524288, 524287, 0, 0));
    add_point(mk_point(300, -200, -1, 1));
    add_point(mk_point(5, 5, 1, 1));
    wait_drained();

    set_rect(32'hFFFFF & -524288, 524287, 524287, 524287, 32'hFFFF_FFFF);
    add_point(mk_point(524287, -524288, -128, 0));
    add_point(mk_point(-524288, 524287, 127, 0));
    add_point(mk_point(1, -1, 1, 1));
    wait_drained();

    set_rect(12345, -678, 0, 1, 32'd1001);
    add_point(mk_point(12345, 10, 1, 0));
    add_point(mk_point(12349, 10, 1, 0));
    add_point(mk_point(-4, -700, 2, 1));
    wait_drained();

    // full set beyond MaxPts
    set_rect(0, 0, 500, 300, 32'd2560);
    for (int i = 0; i < MaxPts + 20; i++)
      add_point(mk_point(rnd_coord(), rnd_coord(), 1, i == MaxPts + 19));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      set_rect($urandom, $urandom, $urandom_range(1, 524287), $urandom_range(0, 3000),
               ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000)));
      queue_sets(120);
      wait_drained();
    end

    // pressure: pause mid-stream until every expected result has come
    set_rect(-1, 1, 1, 524287, 0);
    queue_sets(200);
    while (pending_pts.size() > 100) @(posedge clk);
    hold_off = 1'b1;
    while (expected_resids.size() != 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    wait_drained();
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
